FILE: rtl/lsdu_pkg.sv
// ----------------------------------------------------------------------------
// lsdu_pkg
// Shared types and constants for the LCD shadow-compare character writer.
// ----------------------------------------------------------------------------
package lsdu_pkg;

  localparam logic [7:0] BLANK_CHAR    = 8'h20;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  typedef struct packed {
    logic       start_run;
    logic [7:0] cmd_byte;
    logic [7:0] char_code;
  } job_t;

  function automatic logic [7:0] line_offset(input logic [1:0] row);
    logic [7:0] offset;
    case (row)
      2'd0: offset = 8'h00;
      2'd1: offset = 8'h40;
      2'd2: offset = 8'h14;
      2'd3: offset = 8'h54;
      default: offset = 8'h00;
    endcase
    return offset;
  endfunction

endpackage

FILE: rtl/lsdu_front.sv
// ----------------------------------------------------------------------------
// lsdu_front
// Accepts characters, compares them with the shadow frame and queues jobs.
// ----------------------------------------------------------------------------
module lsdu_front import lsdu_pkg::*; #(
  parameter int LINES   = 4,
  parameter int COLUMNS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic [1:0] row_index,
  input  logic [4:0] column_index,
  output logic       q_push,
  input  logic       q_ready,
  output job_t       q_job
);

  localparam int DEPTH = LINES * COLUMNS;
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       shadow [DEPTH];
  logic [DEPTH-1:0] written;

  logic             in_fire;
  logic             in_range;
  logic [POS_W-1:0] pos;

  logic             s1_valid;
  logic [7:0]       s1_char;
  logic [1:0]       s1_row;
  logic [4:0]       s1_col;
  logic [POS_W-1:0] s1_pos;
  logic             s1_in_range;
  logic [7:0]       rd_data;
  logic             rd_written;
  logic             fwd;
  logic [7:0]       fwd_data;

  logic             prior_changed;
  logic [POS_W-1:0] prior_pos;

  logic [7:0]       shown;
  logic             changed;
  logic             cont;
  logic             s1_fire;

  assign in_range = ({1'b0, row_index} < 3'(LINES)) && ({1'b0, column_index} < 6'(COLUMNS));
  assign pos      = POS_W'(row_index) * POS_W'(COLUMNS) + POS_W'(column_index);
  assign in_fire  = in_valid && in_ready;

  assign shown   = fwd ? fwd_data : (rd_written ? rd_data : BLANK_CHAR);
  assign changed = s1_in_range && (shown != s1_char);
  assign cont    = prior_changed && (s1_col != 5'd0) &&
                   ({1'b0, prior_pos} + (POS_W+1)'(1) == {1'b0, s1_pos});

  assign q_push   = s1_valid && changed && q_ready;
  assign s1_fire  = s1_valid && (!changed || q_ready);
  assign in_ready = !s1_valid || s1_fire;

  assign q_job.start_run = !cont;
  assign q_job.cmd_byte  = CMD_SET_DDRAM | (8'(s1_col) + line_offset(s1_row));
  assign q_job.char_code = s1_char;

  always_ff @(posedge clk) begin
    if (q_push) begin
      shadow[s1_pos] <= s1_char;
    end
    if (in_fire && in_range) begin
      rd_data <= shadow[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char     <= char_code;
      s1_row      <= row_index;
      s1_col      <= column_index;
      s1_pos      <= pos;
      s1_in_range <= in_range;
      fwd         <= q_push && (s1_pos == pos);
      fwd_data    <= s1_char;
      rd_written  <= in_range && written[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      written       <= '0;
      prior_changed <= 1'b0;
      prior_pos     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (q_push) begin
        written[s1_pos] <= 1'b1;
      end
      if (s1_fire) begin
        prior_changed <= changed;
        if (s1_in_range) begin
          prior_pos <= s1_pos;
        end
      end
    end
  end

endmodule

FILE: rtl/lsdu_queue.sv
// ----------------------------------------------------------------------------
// lsdu_queue
// Two-entry job queue between the compare stage and the byte serializer.
// ----------------------------------------------------------------------------
module lsdu_queue import lsdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/lsdu_back.sv
// ----------------------------------------------------------------------------
// lsdu_back
// Serializes each job into expander bytes: two nibbles per byte, three
// bytes per nibble with the enable bit pulsed in the middle one.
// ----------------------------------------------------------------------------
module lsdu_back import lsdu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       backlight_on,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bus_byte,
  output logic       last_of_run
);

  job_t       job;
  logic       busy;
  logic       seg;
  logic       nib;
  logic [1:0] phase;

  logic       out_free;
  logic       is_last;
  logic [7:0] value;
  logic [3:0] nibble;
  logic [7:0] byte_next;

  assign out_free  = !out_valid || out_ready;
  assign is_last   = seg && nib && (phase == 2'd2);
  assign value     = seg ? job.char_code : job.cmd_byte;
  assign nibble    = nib ? value[3:0] : value[7:4];
  assign byte_next = {nibble, backlight_on, (phase == 2'd1), 1'b0, seg};
  assign q_pop     = q_valid && (!busy || (out_free && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      seg         <= 1'b0;
      nib         <= 1'b0;
      phase       <= 2'd0;
      bus_byte    <= 8'h00;
      last_of_run <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
        if (busy) begin
          bus_byte    <= byte_next;
          last_of_run <= is_last;
        end
      end
      if (q_pop) begin
        job   <= q_job;
        busy  <= 1'b1;
        seg   <= !q_job.start_run;
        nib   <= 1'b0;
        phase <= 2'd0;
      end else if (busy && out_free) begin
        if (is_last) begin
          busy <= 1'b0;
        end
        if (phase == 2'd2) begin
          phase <= 2'd0;
          if (nib) begin
            nib <= 1'b0;
            seg <= 1'b1;
          end else begin
            nib <= 1'b1;
          end
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> bus_byte[0] && !bus_byte[2])
    else $error("Final byte of an item is not a data byte without enable.");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> phase != 2'd3)
    else $error("Nibble phase counter out of range.");

  a_enable_followed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && bus_byte[2] |=>
      out_valid && !bus_byte[2] && bus_byte[7:4] == $past(bus_byte[7:4]))
    else $error("Enable byte not followed by matching strobe-low byte.");

endmodule

FILE: rtl/lcd_shadow_diff_updater_core.sv
// ----------------------------------------------------------------------------
// lcd_shadow_diff_updater_core
// Shadow-compare character writer for a 4-bit character LCD on an I2C
// port expander.
// ----------------------------------------------------------------------------
// Usage: characters of a new frame enter on in_valid/in_ready with
// char_code, row_index and column_index. A character equal to the shadow
// copy produces nothing. A changed one updates the shadow and produces six
// expander bytes on out_valid/out_ready, or twelve when an address command
// must precede it because it does not continue a run of changed characters
// along one line. last_of_run marks the final byte of each character.
// The compare stage takes one item per cycle unless a changed one waits
// for queue room; output is one byte per cycle while out_ready holds, so
// the sustained rate is set by the byte serializer. An item passes the
// compare register, the job queue and the serializer job register before
// its first byte is registered at the output. A two-entry job queue lets
// the compare stage keep absorbing items while the serializer works. When
// the receiver stalls, the output byte holds and the queue fills; in_ready
// then drops. Reset empties the pipeline, marks the whole shadow as blanks
// and sets the backlight bit on. cfg_we writes backlight_on from cfg_wdata.
// ----------------------------------------------------------------------------
module lcd_shadow_diff_updater_core import lsdu_pkg::*; #(
  parameter int LINES   = 4,
  parameter int COLUMNS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic [1:0] row_index,
  input  logic [4:0] column_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bus_byte,
  output logic       last_of_run
);

  logic backlight_on;
  logic q_push;
  logic q_push_ready;
  job_t q_push_job;
  logic q_pop;
  logic q_pop_valid;
  job_t q_pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_we) begin
      backlight_on <= cfg_wdata;
    end
  end

  lsdu_front #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .row_index    (row_index),
    .column_index (column_index),
    .q_push       (q_push),
    .q_ready      (q_push_ready),
    .q_job        (q_push_job)
  );

  lsdu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .pop_job    (q_pop_job)
  );

  lsdu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .backlight_on (backlight_on),
    .q_valid      (q_pop_valid),
    .q_job        (q_pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bus_byte     (bus_byte),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: dv/tb_lcd_shadow_diff_updater_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_shadow_diff_updater_core
// Self-checking testbench for the shadow-compare LCD character writer. A
// short table of directed characters, some with typed expander traffic,
// is followed by random raster runs and noise over several backlight
// settings. Every expander byte is checked against typed bytes or a local
// shadow-frame predictor; both handshakes idle randomly but in one phase.
// ----------------------------------------------------------------------------
module tb_lcd_shadow_diff_updater_core;
  import lsdu_pkg::*;

  localparam int LINES   = 4;
  localparam int COLUMNS = 20;
  localparam int NDIR    = 20;
  localparam int NO_CFG  = -1;
  localparam int PREDICT = -1;

  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  typedef struct packed {
    int          cfg;
    logic [7:0]  ch;
    logic [1:0]  row;
    logic [4:0]  col;
    int          n_typed;
    logic [95:0] typed;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic [1:0] row_index;
  logic [4:0] column_index;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] bus_byte;
  logic       last_of_run;

  logic [7:0] shadow [LINES*COLUMNS];
  logic       run_open;
  int         last_pos;
  logic       backlight;

  logic [8:0] char_beats [$];
  logic [8:0] expected_bus [$];

  int in_idle_pct;
  int out_idle_pct;
  int err_count;
  int items_sent;
  int beats_checked;

  dir_row_t dir_tab [NDIR] = '{
    '{1,      8'h41, 2'd0, 5'd0,  12,      96'h888C88_080C08_494D49_191D19},
    '{NO_CFG, 8'h42, 2'd0, 5'd1,  6,       96'h494D49_292D29_000000_000000},
    '{NO_CFG, 8'h20, 2'd0, 5'd2,  0,       96'h0},
    '{NO_CFG, 8'h43, 2'd0, 5'd3,  PREDICT, 96'h0},
    '{NO_CFG, 8'hFF, 2'd0, 5'd19, PREDICT, 96'h0},
    '{NO_CFG, 8'h00, 2'd1, 5'd0,  PREDICT, 96'h0},
    '{NO_CFG, 8'hFF, 2'd3, 5'd19, PREDICT, 96'h0},
    '{NO_CFG, 8'h55, 2'd2, 5'd5,  PREDICT, 96'h0},
    '{NO_CFG, 8'h66, 2'd2, 5'd20, 0,       96'h0},
    '{NO_CFG, 8'h77, 2'd2, 5'd6,  PREDICT, 96'h0},
    '{NO_CFG, 8'h78, 2'd2, 5'd31, 0,       96'h0},
    '{NO_CFG, 8'h41, 2'd0, 5'd0,  0,       96'h0},
    '{NO_CFG, 8'hAA, 2'd1, 5'd10, PREDICT, 96'h0},
    '{NO_CFG, 8'h55, 2'd1, 5'd11, PREDICT, 96'h0},
    '{0,      8'h5A, 2'd0, 5'd0,  PREDICT, 96'h0},
    '{NO_CFG, 8'hA5, 2'd0, 5'd1,  PREDICT, 96'h0},
    '{NO_CFG, 8'h00, 2'd2, 5'd0,  12,      96'h909490_404440_010501_010501},
    '{1,      8'h7E, 2'd3, 5'd18, PREDICT, 96'h0},
    '{NO_CFG, 8'h80, 2'd3, 5'd19, PREDICT, 96'h0},
    '{NO_CFG, 8'h81, 2'd3, 5'd16, PREDICT, 96'h0}
  };

  lcd_shadow_diff_updater_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .row_index    (row_index),
    .column_index (column_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bus_byte     (bus_byte),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d expander bytes still outstanding", expected_bus.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_nibble(input logic [7:0] b, input logic last);
    char_beats.push_back({1'b0, b});
    char_beats.push_back({1'b0, b | 8'h04});
    char_beats.push_back({last, b});
  endtask

  task automatic push_lcd_byte(input logic [7:0] value, input logic rs, input logic is_data);
    logic [7:0] extra;
    extra = {4'b0, backlight, 2'b00, rs};
    push_nibble({value[7:4], 4'b0} | extra, 1'b0);
    push_nibble({value[3:0], 4'b0} | extra, is_data);
  endtask

  task automatic expand_char(input logic [7:0] ch, input logic [1:0] row,
                             input logic [4:0] col);
    int pos;
    logic cont;
    char_beats.delete();
    if (int'(row) >= LINES || int'(col) >= COLUMNS) begin
      run_open = 1'b0;
      return;
    end
    pos = int'(row) * COLUMNS + int'(col);
    if (shadow[pos] == ch) begin
      run_open = 1'b0;
      last_pos = pos;
      return;
    end
    cont = run_open && (col != 5'd0) && (last_pos + 1 == pos);
    if (!cont) begin
      push_lcd_byte(CMD_SET_DDRAM | ({3'b0, col} + ROW_BASE[row]), 1'b0, 1'b0);
    end
    push_lcd_byte(ch, 1'b1, 1'b1);
    shadow[pos] = ch;
    run_open = 1'b1;
    last_pos = pos;
  endtask

  task automatic send_item(input logic [7:0] ch, input logic [1:0] row, input logic [4:0] col,
                           input int n_typed, input logic [95:0] typed);
    expand_char(ch, row, col);
    if (n_typed == PREDICT) begin
      foreach (char_beats[i]) expected_bus.push_back(char_beats[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        expected_bus.push_back({i == n_typed - 1, typed[95 - 8*i -: 8]});
      end
    end
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= ch;
    row_index    <= row;
    column_index <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits for all traffic to drain, then writes the backlight register.
  task automatic write_backlight(input logic value);
    in_valid <= 1'b0;
    while (expected_bus.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    backlight = value;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (expected_bus.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("Unexpected expander byte %h last %b", bus_byte, last_of_run);
        end
      end else begin
        want = expected_bus.pop_front();
        if (bus_byte !== want[7:0] || last_of_run !== want[8]) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Mismatch: expected bus_byte %h last %b, got %h last %b",
                     want[7:0], want[8], bus_byte, last_of_run);
          end
        end
      end
    end
  end

  initial begin
    int pos;
    int len;
    int counted;
    logic [7:0] ch;
    logic [4:0] col;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_valid     = 1'b0;
    char_code    = 8'h00;
    row_index    = 2'd0;
    column_index = 5'd0;
    out_ready    = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    beats_checked = 0;
    in_idle_pct   = 28;
    out_idle_pct  = 28;
    foreach (shadow[i]) shadow[i] = BLANK_CHAR;
    run_open  = 1'b0;
    last_pos  = 0;
    backlight = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NDIR; r++) begin
      if (dir_tab[r].cfg != NO_CFG) write_backlight(dir_tab[r].cfg[0]);
      send_item(dir_tab[r].ch, dir_tab[r].row, dir_tab[r].col,
                dir_tab[r].n_typed, dir_tab[r].typed);
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_backlight(phase == 3 ? 1'($urandom_range(0, 1)) : phase[0]);
      in_idle_pct  = (phase == 2) ? 0 : 28;
      out_idle_pct = (phase == 2) ? 0 : 28;
      counted = 0;
      while (counted < 25) begin
        if ($urandom_range(0, 99) < 75) begin
          // Raster-order run; it may cross a line boundary.
          pos = $urandom_range(0, LINES*COLUMNS - 1);
          len = $urandom_range(1, 8);
          for (int k = 0; k < len && pos < LINES*COLUMNS; k++) begin
            ch = ($urandom_range(0, 3) == 0) ? shadow[pos] : 8'($urandom_range(0, 255));
            send_item(ch, 2'(pos / COLUMNS), 5'(pos % COLUMNS), PREDICT, 96'h0);
            counted++;
            pos++;
          end
        end else begin
          col = 5'($urandom_range(0, 31));
          send_item(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), col,
                    PREDICT, 96'h0);
          if (int'(col) < COLUMNS) counted++;
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_bus.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters over directed and four random backlight phases,", items_sent);
    $display("checked %0d expander bytes, %0d errors.", beats_checked, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: lcd_shadow_diff_updater_core.f
rtl/lsdu_pkg.sv
rtl/lsdu_front.sv
rtl/lsdu_queue.sv
rtl/lsdu_back.sv
rtl/lcd_shadow_diff_updater_core.sv
dv/tb_lcd_shadow_diff_updater_core.sv
